[rtl/scfr_pkg.sv]
// Shared types, constants and the CRC-8 byte update for the framed status receiver.
`default_nettype none

package scfr_pkg;

    // CRC-8 constants: polynomial x^8 + x^2 + x + 1, MSB first
    localparam logic [7:0] CRC_POLY       = 8'h07;
    localparam logic [7:0] CRC_INIT_RESET = 8'h55;
    localparam logic [7:0] SYNC_RESET     = 8'h7E;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_INIT  = 8'd1;

    // Frame phase
    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_LOW   = 2'd1,
        PH_HIGH  = 2'd2,
        PH_CHECK = 2'd3
    } t_phase;

    // Byte held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } t_item;

    // Result of one frame
    typedef struct packed {
        logic        outcome;
        logic [15:0] status_word;
    } t_res;

    // Fold one byte into the CRC, eight shift steps
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/scfr_in_reg.sv]
// Input register: captures one received byte per transfer.
`default_nettype none

module scfr_in_reg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_rx_valid,
    output logic                 o_rx_ready,
    input  wire  [7:0]           i_rx_byte,
    input  wire                  i_adv,
    output scfr_pkg::t_item      o_item
);
    import scfr_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;

    // Take a new byte when empty or when the held byte moves on this cycle
    assign o_rx_ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_valid <= i_rx_valid;
        end
    end

    // Hold the payload until replaced
    always_ff @(posedge i_clk) begin
        if (i_rx_valid && o_rx_ready) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_item.valid   = r_valid;
    assign o_item.rx_byte = r_byte;

endmodule

`default_nettype wire

[rtl/scfr_frame.sv]
// Frame state machine: sync hunt, status assembly, CRC update and check.
`default_nettype none

module scfr_frame (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  scfr_pkg::t_item      i_item,
    input  wire                  i_adv,
    input  wire  [7:0]           i_sync_byte,
    input  wire  [7:0]           i_crc_init,
    output logic                 o_is_check,
    output scfr_pkg::t_res       o_res
);
    import scfr_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_status, n_status;
    logic        mismatch;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_crc    <= CRC_INIT_RESET;
            r_status <= 16'd0;
        end else if (i_adv) begin
            r_phase  <= n_phase;
            r_crc    <= n_crc;
            r_status <= n_status;
        end
    end

    // Next state and result
    always_comb begin
        n_phase  = r_phase;
        n_crc    = r_crc;
        n_status = r_status;
        case (r_phase)
            PH_HUNT: begin
                if (i_item.rx_byte == i_sync_byte) begin
                    n_crc   = i_crc_init;
                    n_phase = PH_LOW;
                end
            end
            PH_LOW: begin
                n_status = {8'd0, i_item.rx_byte};
                n_crc    = crc8_byte(r_crc, i_item.rx_byte);
                n_phase  = PH_HIGH;
            end
            PH_HIGH: begin
                n_status = {i_item.rx_byte, r_status[7:0]};
                n_crc    = crc8_byte(r_crc, i_item.rx_byte);
                n_phase  = PH_CHECK;
            end
            PH_CHECK: begin
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    // Compare check byte; drop status on mismatch
    assign mismatch          = (r_crc != i_item.rx_byte);
    assign o_is_check        = (r_phase == PH_CHECK);
    assign o_res.outcome     = mismatch;
    assign o_res.status_word = mismatch ? 16'd0 : r_status;

    // A check byte always ends the frame
    a_check_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && r_phase == PH_CHECK) |=> (r_phase == PH_HUNT))
        else $error("frame did not return to hunt after check byte");

    // Low status byte is followed by the high status byte
    a_low_to_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && r_phase == PH_LOW) |=> (r_phase == PH_HIGH && r_status[15:8] == 8'd0))
        else $error("low status byte not followed by high phase");

    // State only moves on an advancing byte
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_phase))
        else $error("phase changed without a byte");

endmodule

`default_nettype wire

[rtl/sync_crc8_status_frame_receiver_core.sv]
// A result is registered: its check byte passes the input register, then the result
// register, from which the result is offered for transfer.
// Throughput: one byte per cycle; only a check byte meeting a full, stalled
// result register waits, set by the single result register.
// Reset (i_rst_n low, synchronous): hunt for sync, sync byte 0x7E, CRC seed 0x55,
// both registers empty.
`default_nettype none

module sync_crc8_status_frame_receiver_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_rx_valid,
    output logic        o_rx_ready,
    input  wire  [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  wire         i_res_ready,
    output logic        o_outcome,
    output logic [15:0] o_status_word,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [scfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [7:0]  i_cfg_data
);
    import scfr_pkg::*;

    logic [7:0]  r_sync;
    logic [7:0]  r_crc_init;
    logic        r_out_valid;
    logic        r_outcome;
    logic [15:0] r_status_word;
    t_item       item;
    t_res        res;
    logic        is_check;
    logic        adv;
    logic        emit;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync     <= SYNC_RESET;
            r_crc_init <= CRC_INIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SYNC_BYTE: r_sync     <= i_cfg_data;
                CFG_CRC_INIT:  r_crc_init <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the held byte unless it is a check byte blocked by the result register
    assign adv  = item.valid && (!is_check || !r_out_valid || i_res_ready);
    assign emit = adv && is_check;

    scfr_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_rx_byte  (i_rx_byte),
        .i_adv      (adv),
        .o_item     (item)
    );

    scfr_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item),
        .i_adv       (adv),
        .i_sync_byte (r_sync),
        .i_crc_init  (r_crc_init),
        .o_is_check  (is_check),
        .o_res       (res)
    );

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_outcome     <= res.outcome;
            r_status_word <= res.status_word;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_outcome     = r_outcome;
    assign o_status_word = r_status_word;

    // Never overwrite a result that has not been transferred
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(emit && r_out_valid && !i_res_ready))
        else $error("result register overrun");

    // A check byte produces a result in the next cycle
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_out_valid)
        else $error("check byte without result");

    // A mismatch result carries no status
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_outcome) |-> (r_status_word == 16'd0))
        else $error("mismatch result with nonzero status");

endmodule

`default_nettype wire

[test/tb_sync_crc8_status_frame_receiver_core.sv]
// Testbench for the sync-framed CRC-8 status receiver: queued byte stimulus, scoreboard check.
`timescale 1ns / 100ps

module tb_sync_crc8_status_frame_receiver_core;
    import scfr_pkg::*;

    localparam int unsigned LIMIT_CYCLES    = 200000;
    localparam int unsigned SETTLE_CYCLES   = 6;
    localparam int unsigned PRESSURE_CYCLES = 400;
    localparam int unsigned ITEMS_PER_PHASE = 170;
    localparam int unsigned N_PHASES        = 5;
    localparam int unsigned MAX_REPORTS     = 100;

    // Result outcome codes
    localparam logic OUTCOME_GOOD    = 1'b0;
    localparam logic OUTCOME_CRC_ERR = 1'b1;

    // Register indexes that decode to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 8'hFF;

    // DUT ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_rx_valid = 1'b0;
    logic                 o_rx_ready;
    logic [7:0]           i_rx_byte = 8'h00;
    logic                 o_res_valid;
    logic                 i_res_ready = 1'b0;
    logic                 o_outcome;
    logic [15:0]          o_status_word;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data = 8'h00;

    // Register shadows, at reset values
    logic [7:0] cfg_sync = SYNC_RESET;
    logic [7:0] cfg_crc_init = CRC_INIT_RESET;

    // Frame tracker state
    t_phase      fr_phase = PH_HUNT;
    logic [7:0]  fr_crc = CRC_INIT_RESET;
    logic [15:0] fr_status = 16'h0000;

    // Bytes waiting to be sent and frame results waiting to arrive
    logic [7:0] rx_pending[$];
    t_res       frame_results_due[$];
    t_res       mon_due;

    // Handshake pacing
    int unsigned rx_gap = 0;
    int unsigned rx_gap_max = 0;
    int unsigned res_gap = 0;
    int unsigned res_gap_max = 0;
    int unsigned res_hold = 0;
    logic        hold_req = 1'b0;
    logic        hold_seen = 1'b0;

    // Run statistics
    int unsigned n_errors = 0;
    int unsigned n_bytes = 0;
    int unsigned n_good = 0;
    int unsigned n_bad = 0;
    int unsigned n_cfg_writes = 0;
    int unsigned cycle_count = 0;

    // Per-phase register settings and pacing
    logic [7:0]  ph_sync[N_PHASES];
    logic [7:0]  ph_init[N_PHASES];
    int unsigned ph_rx_gap[N_PHASES];
    int unsigned ph_res_gap[N_PHASES];

    sync_crc8_status_frame_receiver_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .o_rx_ready    (o_rx_ready),
        .i_rx_byte     (i_rx_byte),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .o_outcome     (o_outcome),
        .o_status_word (o_status_word),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // CRC-8, poly 0x07, MSB first: fold one byte into the accumulator
    function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] din);
        logic [7:0] r;
        r = acc ^ din;
        repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Track the frame state for one accepted byte; queue a result on the check byte
    task automatic advance_frame_state(input logic [7:0] rx_val);
        t_res due;
        case (fr_phase)
            PH_HUNT: begin
                if (rx_val == cfg_sync) begin
                    fr_crc   = cfg_crc_init;
                    fr_phase = PH_LOW;
                end
            end
            PH_LOW: begin
                fr_status = {8'h00, rx_val};
                fr_crc    = crc8_fold(fr_crc, rx_val);
                fr_phase  = PH_HIGH;
            end
            PH_HIGH: begin
                fr_status[15:8] = rx_val;
                fr_crc          = crc8_fold(fr_crc, rx_val);
                fr_phase        = PH_CHECK;
            end
            default: begin
                fr_phase = PH_HUNT;
                if (fr_crc == rx_val) begin
                    due.outcome     = OUTCOME_GOOD;
                    due.status_word = fr_status;
                    n_good++;
                end else begin
                    due.outcome     = OUTCOME_CRC_ERR;
                    due.status_word = 16'h0000;
                    n_bad++;
                end
                frame_results_due.push_back(due);
            end
        endcase
    endtask

    // Queue a full frame under the current settings, optionally with one check bit flipped
    task automatic queue_frame(input logic [7:0] lo, input logic [7:0] hi, input logic corrupt);
        logic [7:0] check;
        check = crc8_fold(crc8_fold(cfg_crc_init, lo), hi);
        if (corrupt)
            check = check ^ (8'h01 << $urandom_range(0, 7));
        rx_pending.push_back(cfg_sync);
        rx_pending.push_back(lo);
        rx_pending.push_back(hi);
        rx_pending.push_back(check);
    endtask

    // Mostly clean frames, some bad CRCs, line noise and cut-off frames
    task automatic queue_random_traffic(input int unsigned n_items);
        int unsigned counted;
        int unsigned pick;
        int unsigned cut;
        logic [7:0]  junk;
        counted = 0;
        while (counted < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
                counted += 4;
            end else if (pick < 85) begin
                queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
                counted += 4;
            end else if (pick < 93) begin
                junk = 8'($urandom_range(0, 255));
                if (junk == cfg_sync)
                    junk = ~junk;
                rx_pending.push_back(junk);
            end else begin
                cut = $urandom_range(1, 2);
                rx_pending.push_back(cfg_sync);
                repeat (cut) rx_pending.push_back(8'($urandom_range(0, 255)));
                counted += 1 + cut;
            end
        end
    endtask

    // One register write transfer; update the shadow on acceptance
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] wdata);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= wdata;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_SYNC_BYTE)
            cfg_sync = wdata;
        else if (idx == CFG_CRC_INIT)
            cfg_crc_init = wdata;
        n_cfg_writes++;
    endtask

    // Hold until every byte is sent and every result is back, then let the pipe empty
    task automatic wait_drained();
        while (rx_pending.size() != 0 || i_rx_valid || frame_results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Byte driver: track accepted bytes, then offer the next one after its gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
            rx_gap = 0;
        end else begin
            if (i_rx_valid && o_rx_ready) begin
                advance_frame_state(i_rx_byte);
                n_bytes++;
            end
            if (!i_rx_valid || o_rx_ready) begin
                if (rx_gap > 0) begin
                    rx_gap--;
                    i_rx_valid <= 1'b0;
                end else if (rx_pending.size() != 0) begin
                    i_rx_valid <= 1'b1;
                    i_rx_byte  <= rx_pending.pop_front();
                    rx_gap = $urandom_range(0, rx_gap_max);
                end else begin
                    i_rx_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each transfer against the oldest expected frame
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
            res_gap = 0;
            res_hold = 0;
        end else begin
            if (o_res_valid && i_res_ready) begin
                if (frame_results_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result outcome=%0b status=%04h",
                                              o_outcome, o_status_word));
                end else begin
                    mon_due = frame_results_due.pop_front();
                    if (o_outcome !== mon_due.outcome)
                        report_mismatch($sformatf("outcome got %0b want %0b",
                                                  o_outcome, mon_due.outcome));
                    if (o_status_word !== mon_due.status_word)
                        report_mismatch($sformatf("status_word got %04h want %04h",
                                                  o_status_word, mon_due.status_word));
                end
                res_gap = $urandom_range(0, res_gap_max);
            end
            // Start a long hold-off when one is requested
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                res_hold = PRESSURE_CYCLES;
            end
            if (res_hold > 0) begin
                res_hold--;
                i_res_ready <= 1'b0;
            end else if (res_gap > 0) begin
                res_gap--;
                i_res_ready <= 1'b0;
            end else begin
                i_res_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_sync_crc8_status_frame_receiver_core: FAIL");
            $finish;
        end
    end

    // Sequence: reset, directed frames, then random phases over several settings
    initial begin
        ph_sync[0] = 8'h00;  ph_init[0] = 8'h00;  ph_rx_gap[0] = 0;  ph_res_gap[0] = 0;
        ph_sync[1] = 8'hFF;  ph_init[1] = 8'hFF;  ph_rx_gap[1] = 4;  ph_res_gap[1] = 4;
        ph_sync[2] = 8'($urandom_range(0, 255));  ph_init[2] = 8'($urandom_range(0, 255));
        ph_rx_gap[2] = 0;  ph_res_gap[2] = 4;
        ph_sync[3] = 8'($urandom_range(0, 255));  ph_init[3] = 8'($urandom_range(0, 255));
        ph_rx_gap[3] = 4;  ph_res_gap[3] = 0;
        ph_sync[4] = SYNC_RESET;  ph_init[4] = CRC_INIT_RESET;
        ph_rx_gap[4] = 4;  ph_res_gap[4] = 4;

        // Hold reset, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under reset settings
        @(negedge i_clk);
        rx_gap_max  = 1;
        res_gap_max = 1;
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'hFF);
        queue_frame(8'h00, 8'h00, 1'b0);
        queue_frame(8'hFF, 8'hFF, 1'b0);
        queue_frame(cfg_sync, cfg_sync, 1'b0);
        queue_frame(8'h12, 8'h34, 1'b1);
        rx_pending.push_back(cfg_sync);
        rx_pending.push_back(8'hA5);
        rx_pending.push_back(8'h5A);
        rx_pending.push_back(cfg_sync);
        // Leave a frame open across the next register writes
        rx_pending.push_back(cfg_sync);
        rx_pending.push_back(8'hC3);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            cfg_write(CFG_SYNC_BYTE, ph_sync[p]);
            cfg_write(CFG_CRC_INIT, ph_init[p]);
            if (p == 1) begin
                cfg_write(CFG_IDX_SPARE, 8'($urandom_range(0, 255)));
                cfg_write(CFG_IDX_TOP, 8'($urandom_range(0, 255)));
            end
            @(negedge i_clk);
            rx_gap_max  = ph_rx_gap[p];
            res_gap_max = ph_res_gap[p];
            // Finish the frame left open before the writes
            if (p == 0) begin
                rx_pending.push_back(8'h3C);
                rx_pending.push_back(8'($urandom_range(0, 255)));
            end
            queue_random_traffic(ITEMS_PER_PHASE);
            if (p == 1)
                hold_req = ~hold_req;
            wait_drained();
        end

        $display("covered %0d bytes: %0d good frames, %0d CRC-error frames, %0d register writes",
                 n_bytes, n_good, n_bad, n_cfg_writes);
        $display("settings: reset values, sync/seed at 0x00 and 0xFF, random, one long stall");
        if (n_errors == 0) begin
            $display("tb_sync_crc8_status_frame_receiver_core: PASS");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("tb_sync_crc8_status_frame_receiver_core: FAIL");
        end
        $finish;
    end

endmodule
